@@ sv/plist_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plist_pkg: shared types and codes for the positional list
// Beat structs for both channels, command and status codes, and the cell
// control struct broadcast to the row of storage cells.
// ----------------------------------------------------------------------------
package plist_pkg;

  // command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_LOCATE = 2'd2;

  // status codes
  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_FULL     = 3'd1;
  localparam logic [2:0] STAT_BADPOS   = 3'd2;
  localparam logic [2:0] STAT_EMPTY    = 3'd3;
  localparam logic [2:0] STAT_NOTFOUND = 3'd4;

  // matches per scan step
  localparam int unsigned SCAN_CHUNK = 16;
  localparam int unsigned SCAN_OFF_W = 4;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [6:0]         position;
    logic signed [31:0] item_value;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] status;
    logic [6:0] found_position;
    logic [6:0] list_length;
  } out_beat_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_COMPARE
  } cell_op_e;

  typedef struct packed {
    cell_op_e           op;
    logic signed [31:0] value;
  } cell_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } fsm_e;

endpackage

@@ sv/plist_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plist_cell: one list entry in the cell row
// Holds one word; on insert takes its left neighbor or the new value, on
// delete takes its right neighbor, on locate registers an equality match.
// ----------------------------------------------------------------------------
module plist_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned XW  = 8,
  parameter int unsigned CW  = 7
) (
  input  logic                  clk,
  input  logic                  rst,
  input  plist_pkg::cell_ctrl_t ctrl,
  input  logic [XW-1:0]         pos_idx,
  input  logic [CW-1:0]         count,
  input  logic signed [31:0]    left_data,
  input  logic signed [31:0]    right_data,
  output logic signed [31:0]    data,
  output logic                  match
);

  localparam logic [XW-1:0] MY_IDX = XW'(IDX);
  localparam logic [CW-1:0] MY_CNT = CW'(IDX);

  // entry word, shifted along the row
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      plist_pkg::OP_INSERT: begin
        if (MY_IDX > pos_idx) begin
          data <= left_data;
        end else if (MY_IDX == pos_idx) begin
          data <= ctrl.value;
        end
      end
      plist_pkg::OP_DELETE: begin
        if (MY_IDX >= pos_idx) begin
          data <= right_data;
        end
      end
      default: begin
      end
    endcase
  end

  // match flag, only for live entries
  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctrl.op == plist_pkg::OP_COMPARE) begin
      match <= (data == ctrl.value) && (MY_CNT < count);
    end
  end

endmodule

@@ sv/positional_list_insert_delete_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_insert_delete_search: ordered list of signed words
// Row of storage cells with a length counter; insert, delete and locate.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat (request) is taken at a rising edge where start is high
//   and busy is low. Every command gives exactly one response beat, shown
//   for one cycle with done high; the receiver cannot stall it.
//   Insert, delete, rejected commands and locate on an empty list finish
//   in the accepting cycle: done rises on the next cycle and busy stays low,
//   so such commands can be issued every cycle.
//   Locate registers a match flag in every cell in the accepting cycle,
//   then scans the flags 16 cells per cycle for the first hit. busy is high
//   during the scan; the response beat follows the chunk that holds the
//   first hit, or the last chunk if no flag is set.
//   Reset clears the length to zero and returns to idle; entry words are
//   not cleared and are never read before they are written.
//   list_length and found_position carry the low 7 bits of their values.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_search #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  plist_pkg::in_beat_t  request,
  output logic                 done,
  output plist_pkg::out_beat_t response
);

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned XW   = ((CW > 7) ? CW : 7) + 1;
  localparam int unsigned CH   = plist_pkg::SCAN_CHUNK;
  localparam int unsigned OW   = plist_pkg::SCAN_OFF_W;
  localparam int unsigned NCH  = (CAPACITY + CH - 1) / CH;
  localparam int unsigned CKW  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int unsigned PADW = NCH * CH;
  localparam int unsigned FPW  = CKW + OW + 1;

  plist_pkg::fsm_e       state, state_next;
  logic [CW-1:0]         count, count_next;
  logic [CKW-1:0]        chunk, chunk_next;
  logic                  done_next;
  plist_pkg::out_beat_t  response_next;

  logic                  accept;
  logic [XW-1:0]         pos_x, cnt_x, pos_idx;
  logic                  full, empty, ins_ok, del_ok;
  logic [2:0]            status_imm;
  plist_pkg::cell_ctrl_t ctrl;

  logic signed [31:0]    cell_data [CAPACITY];
  logic [CAPACITY-1:0]   match_vec;
  logic [PADW-1:0]       match_pad;
  logic [CH-1:0]         chunk_bits;
  logic                  hit;
  logic [OW-1:0]         hit_off;
  logic                  last_chunk;
  logic [FPW-1:0]        found_pos;

  assign busy   = (state == plist_pkg::ST_SCAN);
  assign accept = start & ~busy;

  // command checks against the current length
  assign pos_x   = XW'(request.position);
  assign cnt_x   = XW'(count);
  assign pos_idx = pos_x - XW'(1);
  assign full    = (count == CW'(CAPACITY));
  assign empty   = (count == '0);
  assign ins_ok  = !full && (pos_x != '0) && (pos_x <= cnt_x + XW'(1));
  assign del_ok  = !empty && (pos_x != '0) && (pos_x <= cnt_x);

  always_comb begin
    unique case (request.cmd)
      plist_pkg::CMD_INSERT:
        status_imm = full ? plist_pkg::STAT_FULL
                   : (ins_ok ? plist_pkg::STAT_OK : plist_pkg::STAT_BADPOS);
      plist_pkg::CMD_DELETE:
        status_imm = empty ? plist_pkg::STAT_EMPTY
                   : (del_ok ? plist_pkg::STAT_OK : plist_pkg::STAT_BADPOS);
      plist_pkg::CMD_LOCATE:
        status_imm = empty ? plist_pkg::STAT_EMPTY : plist_pkg::STAT_OK;
      default:
        status_imm = plist_pkg::STAT_BADPOS;
    endcase
  end

  // broadcast to the cell row
  always_comb begin
    ctrl.value = request.item_value;
    ctrl.op    = plist_pkg::OP_HOLD;
    if (accept) begin
      unique case (request.cmd)
        plist_pkg::CMD_INSERT: if (ins_ok) ctrl.op = plist_pkg::OP_INSERT;
        plist_pkg::CMD_DELETE: if (del_ok) ctrl.op = plist_pkg::OP_DELETE;
        plist_pkg::CMD_LOCATE: ctrl.op = plist_pkg::OP_COMPARE;
        default: ctrl.op = plist_pkg::OP_HOLD;
      endcase
    end
  end

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] left_d, right_d;
    if (i == 0) begin : g_first
      assign left_d = request.item_value;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end
    plist_cell #(
      .IDX (i),
      .XW  (XW),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .pos_idx    (pos_idx),
      .count      (count),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i]),
      .match      (match_vec[i])
    );
  end

  // first-hit scan, one chunk of match flags per cycle
  assign match_pad  = PADW'(match_vec);
  assign chunk_bits = match_pad[{chunk, {OW{1'b0}}} +: CH];
  assign hit        = |chunk_bits;
  assign last_chunk = (chunk == CKW'(NCH - 1));
  assign found_pos  = FPW'({chunk, hit_off}) + FPW'(1);

  always_comb begin
    hit_off = '0;
    for (int k = CH - 1; k >= 0; k--) begin
      if (chunk_bits[k]) hit_off = OW'(k);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      plist_pkg::ST_IDLE: begin
        if (accept && request.cmd == plist_pkg::CMD_LOCATE && !empty) begin
          state_next = plist_pkg::ST_SCAN;
        end
      end
      plist_pkg::ST_SCAN: begin
        if (hit || last_chunk) state_next = plist_pkg::ST_IDLE;
      end
      default: state_next = plist_pkg::ST_IDLE;
    endcase
  end

  // outputs, length and scan pointer
  always_comb begin
    count_next    = count;
    chunk_next    = chunk;
    done_next     = 1'b0;
    response_next = response;
    unique case (state)
      plist_pkg::ST_IDLE: begin
        if (accept) begin
          if (ctrl.op == plist_pkg::OP_INSERT) count_next = count + CW'(1);
          if (ctrl.op == plist_pkg::OP_DELETE) count_next = count - CW'(1);
          if (state_next == plist_pkg::ST_SCAN) begin
            chunk_next = '0;
          end else begin
            done_next                    = 1'b1;
            response_next.status         = status_imm;
            response_next.found_position = '0;
            response_next.list_length    = 7'(count_next);
          end
        end
      end
      plist_pkg::ST_SCAN: begin
        if (hit) begin
          done_next                    = 1'b1;
          response_next.status         = plist_pkg::STAT_OK;
          response_next.found_position = 7'(found_pos);
          response_next.list_length    = 7'(count);
        end else if (last_chunk) begin
          done_next                    = 1'b1;
          response_next.status         = plist_pkg::STAT_NOTFOUND;
          response_next.found_position = '0;
          response_next.list_length    = 7'(count);
        end else begin
          chunk_next = chunk + CKW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= plist_pkg::ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    chunk    <= chunk_next;
    response <= response_next;
  end

  // a response beat never overlaps a scan
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("response beat while scan in progress");

  // length stays within the store
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("list length above capacity");

  // length moves by at most one per command
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count == $past(count)) || (count == $past(count) + CW'(1)) ||
    (count == $past(count) - CW'(1)))
    else $error("list length jumped");

  // locate on a non-empty list starts a scan
  a_locate_scan: assert property (@(posedge clk) disable iff (rst)
    (accept && request.cmd == plist_pkg::CMD_LOCATE && !empty) |=> busy && !done)
    else $error("locate did not start a scan");

endmodule
